@@ rtl/core/earliest_deadline_event_table_assert.svh @@
// assertion helpers, clocked on clk and held off during rst
`ifndef EARLIEST_DEADLINE_EVENT_TABLE_ASSERT_SVH
`define EARLIEST_DEADLINE_EVENT_TABLE_ASSERT_SVH

// same-cycle implication
`define EDET_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edet assertion failed");

// next-cycle implication
`define EDET_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edet assertion failed");

`endif

@@ rtl/core/edet_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package edet_pkg;

  localparam int NUM_TYPES   = 16;
  localparam int TYPE_W      = $clog2(NUM_TYPES);
  localparam int TIME_W      = 32;
  localparam int MASK_W      = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TIME_W-1:0] IMMEDIATE_TIME = TIME_W'(1);

  localparam logic [3:0] CMD_SCHEDULE = 4'd0;
  localparam logic [3:0] CMD_FORCE    = 4'd1;
  localparam logic [3:0] CMD_FIRE     = 4'd2;
  localparam logic [3:0] CMD_TAKE     = 4'd3;
  localparam logic [3:0] CMD_DONE     = 4'd4;
  localparam logic [3:0] CMD_ENQUEUE  = 4'd5;
  localparam logic [3:0] CMD_FREEZE   = 4'd6;
  localparam logic [3:0] CMD_START    = 4'd7;
  localparam logic [3:0] CMD_SET_UF   = 4'd8;
  localparam logic [3:0] CMD_QUERY    = 4'd9;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_ARM    = 3'd1;
  localparam logic [2:0] ACT_START  = 3'd2;
  localparam logic [2:0] ACT_EXEC   = 3'd3;
  localparam logic [2:0] ACT_CANCEL = 3'd4;
  localparam logic [2:0] ACT_QUERY  = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SCHEDULE,
    OP_FORCE,
    OP_FIRE,
    OP_TAKE,
    OP_DONE,
    OP_ENQUEUE,
    OP_FREEZE,
    OP_START,
    OP_SET_UF,
    OP_QUERY
  } op_t;

  typedef struct packed {
    logic [3:0]        command;
    logic [TYPE_W-1:0] event_type;
    logic [TIME_W-1:0] planned_time;
    logic [TIME_W-1:0] now_time;
    logic              flag_value;
  } req_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [TIME_W-1:0] timer_delay;
    logic [TYPE_W-1:0] chosen_type;
    logic [TIME_W-1:0] chosen_time;
    logic [TIME_W-1:0] queried_time;
    logic              busy_res;
  } rsp_t;

  typedef struct packed {
    op_t               op;
    logic [TYPE_W-1:0] event_type;
    logic              type_ok;
    logic [TIME_W-1:0] value;
    logic [TIME_W-1:0] now_time;
    logic              flag_value;
  } item_t;

endpackage
`default_nettype wire

@@ rtl/core/earliest_deadline_event_table.sv @@
// every command scans the 16-entry deadline table once; schedule, user force and a
// non-bypass enqueue scan it a second time
// pacing: the back end takes one request at a time, held up by the 16-entry deadline scan
// through the single read port of the deadline memory
// reset: synchronous rst; the deadline table reads as zero at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module earliest_deadline_event_table (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  edet_pkg::req_t                   req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output edet_pkg::rsp_t                   rsp,
  input  wire logic                        cfg_we,
  input  wire logic [edet_pkg::MASK_W-1:0] cfg_wdata
);
  import edet_pkg::*;

  logic [MASK_W-1:0] freeze_mask;
  logic              f_valid;
  item_t             f_item;
  logic              f_ready;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      freeze_mask <= '0;
    end else if (cfg_we) begin
      freeze_mask <= cfg_wdata;
    end
  end

  edet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  edet_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_item  (f_item),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  edet_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (q_valid),
    .item        (q_item),
    .item_pop    (q_pop),
    .freeze_mask (freeze_mask),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

endmodule
`default_nettype wire

@@ rtl/core/edet_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module edet_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  edet_pkg::req_t     req,
  output logic               item_valid,
  output edet_pkg::item_t    item,
  input  wire logic          item_ready
);
  import edet_pkg::*;

  item_t item_next;
  logic  type_ok;
  logic  hold_valid;
  item_t hold;

  always_comb begin
    type_ok = (req.event_type != '0) && (int'(req.event_type) < NUM_TYPES);
    item_next.event_type = req.event_type;
    item_next.type_ok    = type_ok;
    item_next.value      = req.planned_time;
    item_next.now_time   = req.now_time;
    item_next.flag_value = req.flag_value;
    item_next.op         = OP_NONE;
    unique case (req.command)
      CMD_SCHEDULE: begin
        if (type_ok) item_next.op = OP_SCHEDULE;
      end
      CMD_FORCE: begin
        item_next.value = req.now_time;
        if (type_ok) item_next.op = OP_FORCE;
      end
      CMD_FIRE:    item_next.op = OP_FIRE;
      CMD_TAKE:    item_next.op = OP_TAKE;
      CMD_DONE:    item_next.op = OP_DONE;
      CMD_ENQUEUE: begin
        item_next.value = req.now_time;
        if (type_ok) item_next.op = OP_ENQUEUE;
      end
      CMD_FREEZE:  item_next.op = OP_FREEZE;
      CMD_START:   item_next.op = OP_START;
      CMD_SET_UF:  item_next.op = OP_SET_UF;
      CMD_QUERY:   item_next.op = OP_QUERY;
      default:     item_next.op = OP_NONE;
    endcase
  end

  assign req_stall  = hold_valid && !item_ready;
  assign item_valid = hold_valid;
  assign item       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!hold_valid || item_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= item_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/edet_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module edet_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  edet_pkg::item_t    push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output edet_pkg::item_t    pop_item,
  input  wire logic          pop
);
  import edet_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  cnt;
  logic              do_push;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = cnt != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt != '0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop) rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

@@ rtl/core/edet_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "earliest_deadline_event_table_assert.svh"
module edet_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  input  edet_pkg::item_t                  item,
  output logic                             item_pop,
  input  wire logic [edet_pkg::MASK_W-1:0] freeze_mask,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output edet_pkg::rsp_t                   rsp
);
  import edet_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SCAN_END,
    S_EXEC,
    S_FINISH,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_CUR,
    TAG_SCAN
  } tag_t;

  typedef enum logic [1:0] {
    RS_NONE,
    RS_ALWAYS,
    RS_CHANGED
  } rs_t;

  state_t             state;
  item_t              cur_item;
  logic [TYPE_W-1:0]  scan_idx;
  logic               pass2;
  logic [TYPE_W-1:0]  best;
  logic [TIME_W-1:0]  bt;
  logic [TIME_W-1:0]  bt_first;
  logic [TIME_W-1:0]  cur;
  tag_t               rd_tag;
  logic [TYPE_W-1:0]  rd_idx;
  rs_t                resched;
  rsp_t               res;
  logic               running;
  logic               frozen;
  logic               uf;
  logic [NUM_TYPES-1:0] forced;
  logic [NUM_TYPES-1:0] valid_bits;

  logic [TIME_W-1:0]  mem [NUM_TYPES];
  logic [TIME_W-1:0]  mem_q;
  logic               vld_q;
  logic [TIME_W-1:0]  rd_val;
  logic [TYPE_W-1:0]  rd_addr;

  logic               wr_en;
  logic [TYPE_W-1:0]  wr_addr;
  logic [TIME_W-1:0]  wr_data;
  logic [TYPE_W-1:0]  t;
  logic [TIME_W-1:0]  val;
  logic               sched_ok;
  logic               bypass;
  logic               out_load;

  function automatic logic elig(input logic [TYPE_W-1:0] i);
    return forced[i] || !uf || !freeze_mask[i];
  endfunction

  assign rd_val   = vld_q ? mem_q : '0;
  assign item_pop = (state == S_IDLE) && item_valid;
  assign rd_addr  = (state == S_READ) ? cur_item.event_type : scan_idx;
  assign out_load = (state == S_OUT) && (!rsp_valid || !rsp_stall);

  always_comb begin
    t        = cur_item.event_type;
    val      = cur_item.value;
    sched_ok = (cur == '0) ||
               ((val == '0) && !forced[t] && (cur_item.op != OP_FORCE)) ||
               ((val != '0) && (val < cur));
    bypass   = !running && !frozen && (!uf || !freeze_mask[t]);
    wr_en    = 1'b0;
    wr_addr  = t;
    wr_data  = val;
    if (state == S_EXEC) begin
      unique case (cur_item.op)
        OP_SCHEDULE, OP_FORCE: wr_en = sched_ok;
        OP_ENQUEUE: begin
          wr_en = bypass || sched_ok;
          if (bypass) wr_data = IMMEDIATE_TIME;
        end
        OP_TAKE: begin
          wr_en   = best != '0;
          wr_addr = best;
          wr_data = '0;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // deadline memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
    vld_q <= valid_bits[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_tag    <= TAG_NONE;
      running   <= 1'b0;
      frozen    <= 1'b0;
      uf        <= 1'b0;
      forced    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      rd_tag <= TAG_NONE;
      rd_idx <= scan_idx;

      if (rd_tag == TAG_CUR) cur <= rd_val;
      if ((rd_tag == TAG_SCAN) && (rd_val != '0) && ((bt == '0) || (rd_val < bt)) &&
          elig(rd_idx)) begin
        bt   <= rd_val;
        best <= rd_idx;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_item <= item;
            state    <= S_READ;
          end
        end
        S_READ: begin
          rd_tag   <= TAG_CUR;
          scan_idx <= '0;
          best     <= '0;
          bt       <= '0;
          pass2    <= 1'b0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          rd_tag   <= TAG_SCAN;
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == TYPE_W'(NUM_TYPES - 1)) state <= S_SCAN_END;
        end
        S_SCAN_END: begin
          state <= pass2 ? S_FINISH : S_EXEC;
        end
        S_EXEC: begin
          res     <= '0;
          resched <= RS_NONE;
          state   <= S_OUT;
          unique case (cur_item.op)
            OP_SCHEDULE: begin
              resched  <= RS_CHANGED;
              bt_first <= bt;
              best     <= '0;
              bt       <= '0;
              scan_idx <= '0;
              pass2    <= 1'b1;
              state    <= S_SCAN;
            end
            OP_FORCE: begin
              forced[t] <= 1'b1;
              resched   <= RS_ALWAYS;
              bt_first  <= bt;
              best      <= '0;
              bt        <= '0;
              scan_idx  <= '0;
              pass2     <= 1'b1;
              state     <= S_SCAN;
            end
            OP_FIRE: begin
              if (!running && !frozen) begin
                running    <= 1'b1;
                res.action <= ACT_START;
              end
            end
            OP_TAKE: begin
              if (best == '0) begin
                running <= 1'b0;
              end else begin
                res.action      <= ACT_EXEC;
                res.chosen_type <= best;
                res.chosen_time <= bt;
                forced[best]    <= 1'b0;
              end
            end
            OP_DONE: begin
              running <= 1'b0;
              resched <= RS_ALWAYS;
              state   <= S_FINISH;
            end
            OP_ENQUEUE: begin
              if (bypass) begin
                running         <= 1'b1;
                res.action      <= ACT_START;
                res.chosen_type <= t;
                res.chosen_time <= IMMEDIATE_TIME;
              end else begin
                resched  <= RS_CHANGED;
                bt_first <= bt;
                best     <= '0;
                bt       <= '0;
                scan_idx <= '0;
                pass2    <= 1'b1;
                state    <= S_SCAN;
              end
            end
            OP_FREEZE: begin
              frozen     <= 1'b1;
              res.action <= ACT_CANCEL;
            end
            OP_START: begin
              frozen  <= 1'b0;
              resched <= RS_ALWAYS;
              state   <= S_FINISH;
            end
            OP_SET_UF: uf <= cur_item.flag_value;
            OP_QUERY: begin
              res.action       <= ACT_QUERY;
              res.chosen_type  <= best;
              res.chosen_time  <= bt;
              res.queried_time <= cur_item.type_ok ? cur : '0;
            end
            default: res.action <= ACT_NONE;
          endcase
        end
        S_FINISH: begin
          if (!running && !frozen && (best != '0) &&
              ((resched == RS_ALWAYS) || (bt != bt_first))) begin
            res.action      <= ACT_ARM;
            res.timer_delay <= (cur_item.now_time < bt) ? bt - cur_item.now_time : '0;
            res.chosen_type <= best;
            res.chosen_time <= bt;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            rsp_valid    <= 1'b1;
            rsp          <= res;
            rsp.busy_res <= running;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `EDET_ASSERT_IMPL(a_arm_idle, rsp_valid && rsp.action == ACT_ARM, rsp.chosen_type != '0 && !rsp.busy_res)
  `EDET_ASSERT_IMPL(a_start_busy, rsp_valid && rsp.action == ACT_START, rsp.busy_res)
  `EDET_ASSERT_NEXT(a_scan_flow, state == S_SCAN, state == S_SCAN || state == S_SCAN_END)
  `EDET_ASSERT_NEXT(a_load_done, out_load, rsp_valid && state == S_IDLE)

endmodule
`default_nettype wire
